/* hdl/annexb_nal_start_code_splitter_top_assert.svh */
// Assertion macros shared by the splitter RTL.
`ifndef ANNEXB_NAL_START_CODE_SPLITTER_TOP_ASSERT_SVH
`define ANNEXB_NAL_START_CODE_SPLITTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ANNEXB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("annexb assertion failed");

// Next-cycle implication, disabled during reset.
`define ANNEXB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("annexb assertion failed");

`endif

/* hdl/annexb_pkg.sv */
package annexb_pkg;

   localparam int WinDepth   = 5;
   localparam int MaxResults = 6;
   localparam int FillWidth  = $clog2(WinDepth + 1);
   localparam int CountWidth = $clog2(MaxResults + 1);
   localparam int LongCodeLen  = 4;
   localparam int ShortCodeLen = 3;
   localparam int PayloadDrop  = 1;

   localparam logic [7:0] ZeroByte = 8'h00;
   localparam logic [7:0] OneByte  = 8'h01;

   typedef enum logic [1:0] {
      MatchNone,
      MatchLong,
      MatchShort
   } match_type;

   typedef struct packed {
      logic [WinDepth-1:0][7:0] win;
      logic [FillWidth-1:0]     fill;
      logic                     inside_unit;
      logic [7:0]               held_byte;
      logic                     held_valid;
      logic                     held_first;
   } state_type;

   typedef struct packed {
      logic [7:0] nal_byte;
      logic       nal_first;
      logic       nal_last;
   } result_type;

endpackage

/* hdl/annexb_if.sv */
interface annexb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface annexb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] nal_byte;
   logic       nal_first;
   logic       nal_last;

   modport source (output valid, output nal_byte, output nal_first, output nal_last,
                   input ready);
   modport sink (input valid, input nal_byte, input nal_first, input nal_last,
                 output ready);
endinterface

/* hdl/annexb_nal_start_code_splitter_top.sv */
// Channel   Dir   Payload                          Transaction when
// req_bus   in    data_byte[7:0], final_byte       valid && ready
// rsp_bus   out   nal_byte[7:0], nal_first, last   valid && ready
//
// One byte is taken per cycle while ready; its results (zero or one in steady
// state, up to six on a final byte) land in a six-entry result shift register.
// A new byte is taken while the last pending result leaves; a byte's results
// leave one at a time through the single result port.
// Synchronous active-high reset clears the window, unit state and result count.
// A stalled rsp_bus holds the result register and backs up req_bus.
`include "annexb_nal_start_code_splitter_top_assert.svh"

module annexb_nal_start_code_splitter_top (
   input  logic         clock,
   input  logic         reset,
   annexb_req_if.sink   req_bus,
   annexb_rsp_if.source rsp_bus
);

   annexb_pkg::state_type state_ff, state_in;
   annexb_pkg::result_type [annexb_pkg::MaxResults-1:0] results;
   annexb_pkg::result_type [annexb_pkg::MaxResults-1:0] rbuf_ff, rbuf_in;
   logic [annexb_pkg::CountWidth-1:0] count;
   logic [annexb_pkg::CountWidth-1:0] rem_ff, rem_in;
   logic req_take, rsp_take;

   annexb_scan u_scan (
      .state_ff   (state_ff),
      .data_byte  (req_bus.data_byte),
      .final_byte (req_bus.final_byte),
      .state_in   (state_in),
      .results    (results),
      .count      (count)
   );

   assign rsp_bus.valid     = (rem_ff != '0);
   assign rsp_bus.nal_byte  = rbuf_ff[0].nal_byte;
   assign rsp_bus.nal_first = rbuf_ff[0].nal_first;
   assign rsp_bus.nal_last  = rbuf_ff[0].nal_last;

   assign rsp_take      = rsp_bus.valid && rsp_bus.ready;
   assign req_bus.ready = (rem_ff == '0) ||
                          (rem_ff == annexb_pkg::CountWidth'(1) && rsp_bus.ready);
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      rem_in  = rem_ff;
      rbuf_in = rbuf_ff;
      if (req_take) begin
         rbuf_in = results;
         rem_in  = count;
      end else if (rsp_take) begin
         rbuf_in = rbuf_ff >> $bits(annexb_pkg::result_type);
         rem_in  = rem_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         rem_ff   <= '0;
      end else begin
         rem_ff <= rem_in;
         if (req_take) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rbuf_ff <= rbuf_in;
   end

   `ANNEXB_ASSERT_IMP(a_fill_below_depth, clock, reset, 1'b1,
                      state_ff.fill < annexb_pkg::FillWidth'(annexb_pkg::WinDepth))
   `ANNEXB_ASSERT_IMP(a_held_inside_unit, clock, reset, state_ff.held_valid,
                      state_ff.inside_unit)
   `ANNEXB_ASSERT_NEXT(a_final_clears, clock, reset, req_take && req_bus.final_byte,
                       state_ff.fill == '0 && !state_ff.inside_unit && !state_ff.held_valid)
   `ANNEXB_ASSERT_NEXT(a_drain_count, clock, reset, rsp_take && !req_take,
                       rem_ff == $past(rem_ff) - 1'b1)

endmodule

/* hdl/annexb_scan.sv */
module annexb_scan (
   input  annexb_pkg::state_type                              state_ff,
   input  logic [7:0]                                         data_byte,
   input  logic                                               final_byte,
   output annexb_pkg::state_type                              state_in,
   output annexb_pkg::result_type [annexb_pkg::MaxResults-1:0] results,
   output logic [annexb_pkg::CountWidth-1:0]                  count
);

   always_comb begin
      annexb_pkg::state_type s;
      annexb_pkg::result_type [annexb_pkg::MaxResults-1:0] res;
      logic [annexb_pkg::CountWidth-1:0] cnt;
      logic [annexb_pkg::FillWidth-1:0] drop;
      annexb_pkg::match_type kind;

      s    = state_ff;
      res  = '0;
      cnt  = '0;
      drop = '0;
      kind = annexb_pkg::MatchNone;

      if (s.fill < annexb_pkg::FillWidth'(annexb_pkg::WinDepth)) begin
         s.win[s.fill] = data_byte;
         s.fill = s.fill + 1'b1;
      end

      if (s.fill == annexb_pkg::FillWidth'(annexb_pkg::WinDepth)) begin
         if (s.win[0] == annexb_pkg::ZeroByte && s.win[1] == annexb_pkg::ZeroByte &&
             s.win[2] == annexb_pkg::ZeroByte && s.win[3] == annexb_pkg::OneByte) begin
            kind = annexb_pkg::MatchLong;
         end else if (s.win[0] == annexb_pkg::ZeroByte &&
                      s.win[1] == annexb_pkg::ZeroByte &&
                      s.win[2] == annexb_pkg::OneByte) begin
            kind = annexb_pkg::MatchShort;
         end

         if (kind != annexb_pkg::MatchNone) begin
            // close the running unit
            if (s.held_valid && cnt < annexb_pkg::CountWidth'(annexb_pkg::MaxResults)) begin
               res[cnt] = '{nal_byte: s.held_byte, nal_first: s.held_first, nal_last: 1'b1};
               cnt = cnt + 1'b1;
            end
            s.held_valid  = 1'b0;
            s.held_first  = 1'b0;
            s.held_byte   = '0;
            s.inside_unit = 1'b1;
            drop = (kind == annexb_pkg::MatchLong) ?
                   annexb_pkg::FillWidth'(annexb_pkg::LongCodeLen) :
                   annexb_pkg::FillWidth'(annexb_pkg::ShortCodeLen);
         end else begin
            if (s.inside_unit) begin
               if (s.held_valid &&
                   cnt < annexb_pkg::CountWidth'(annexb_pkg::MaxResults)) begin
                  res[cnt] = '{nal_byte: s.held_byte, nal_first: s.held_first,
                               nal_last: 1'b0};
                  cnt = cnt + 1'b1;
               end
               s.held_first = !s.held_valid;
               s.held_byte  = s.win[0];
               s.held_valid = 1'b1;
            end
            drop = annexb_pkg::FillWidth'(annexb_pkg::PayloadDrop);
         end

         s.win  = s.win >> {drop, 3'b000};
         s.fill = s.fill - drop;
      end

      if (final_byte) begin
         // flush window as payload, then close
         for (int i = 0; i < annexb_pkg::WinDepth; i++) begin
            if (annexb_pkg::FillWidth'(i) < s.fill && s.inside_unit) begin
               if (s.held_valid &&
                   cnt < annexb_pkg::CountWidth'(annexb_pkg::MaxResults)) begin
                  res[cnt] = '{nal_byte: s.held_byte, nal_first: s.held_first,
                               nal_last: 1'b0};
                  cnt = cnt + 1'b1;
               end
               s.held_first = !s.held_valid;
               s.held_byte  = s.win[i];
               s.held_valid = 1'b1;
            end
         end
         if (s.held_valid && cnt < annexb_pkg::CountWidth'(annexb_pkg::MaxResults)) begin
            res[cnt] = '{nal_byte: s.held_byte, nal_first: s.held_first, nal_last: 1'b1};
            cnt = cnt + 1'b1;
         end
         s = '0;
      end

      state_in = s;
      results  = res;
      count    = cnt;
   end

endmodule
